// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the date adder RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge, off while in reset.
`define WDDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define WDDA_ASSERT_IMPL(lbl, cond, cons, msg) \
  `WDDA_ASSERT(lbl, (cond) |-> (cons), msg)

`endif

// ----- rtl/wdda_pkg.sv -----
// Types, constants and calendar tables for the working-day date adder.
// No dependencies.
package wdda_pkg;

  localparam int REM_W = 14;

  localparam logic [13:0] YEAR_MIN = 14'd1;
  localparam logic [13:0] YEAR_MAX = 14'd9999;
  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_DEC = 4'd12;
  localparam logic [6:0]  CENT_LAST = 7'd99;
  localparam logic [6:0]  MASK_ALL = 7'h7f;
  localparam logic [6:0]  MASK_RESET = 7'd96;
  localparam logic [2:0]  WD_SAT = 3'd6;

  localparam logic [REM_W-1:0] DIV_400 = 14'd400;
  localparam logic [REM_W-1:0] DIV_100 = 14'd100;
  localparam logic [REM_W-1:0] DIV_4 = 14'd4;
  localparam logic [REM_W-1:0] DIV_7 = 14'd7;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [6:0]  c100;
    logic [1:0]  c400;
  } wdda_date_t;

  typedef struct packed {
    wdda_date_t next;
    logic [4:0] mlen;
    logic       overflow;
  } wdda_step_t;

  function automatic logic [4:0] month_days(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd2: len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Month term of the weekday formula, reduced mod 7.
  function automatic logic [2:0] month_offset(input logic [3:0] m);
    logic [2:0] off;
    unique case (m)
      4'd2, 4'd6: off = 3'd3;
      4'd3, 4'd11: off = 3'd2;
      4'd4, 4'd7: off = 3'd5;
      4'd8: off = 3'd1;
      4'd9, 4'd12: off = 3'd4;
      4'd10: off = 3'd6;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- rtl/wdda_div_unit.sv -----
// Shared compare-and-subtract unit of the date adder sequencer.
// Depends on wdda_pkg.
module wdda_div_unit
  import wdda_pkg::*;
(
  input  logic [REM_W-1:0] rem,
  input  logic [REM_W-1:0] divisor,
  output logic [REM_W-1:0] diff,
  output logic             ge
);

  assign ge   = (rem >= divisor);
  assign diff = rem - divisor;

endmodule

// ----- rtl/wdda_cal_step.sv -----
// Next-calendar-day logic: month length, leap year and year rollover.
// Depends on wdda_pkg.
module wdda_cal_step
  import wdda_pkg::*;
(
  input  wdda_date_t cur,
  output wdda_step_t step
);

  logic leap;
  logic [4:0] mlen;

  always_comb begin
    leap = ((cur.year[1:0] == 2'd0) && (cur.c100 != 7'd0)) ||
           ((cur.c100 == 7'd0) && (cur.c400 == 2'd0));
    if (cur.month == MONTH_FEB) begin
      mlen = leap ? 5'd29 : 5'd28;
    end else begin
      mlen = month_days(cur.month);
    end
  end

  always_comb begin
    step.next     = cur;
    step.mlen     = mlen;
    step.overflow = 1'b0;
    if (cur.day >= mlen) begin
      step.next.day = 5'd1;
      if (cur.month >= MONTH_DEC) begin
        if (cur.year >= YEAR_MAX) begin
          step.next     = cur;
          step.overflow = 1'b1;
        end else begin
          step.next.year  = cur.year + 14'd1;
          step.next.month = 4'd1;
          if (cur.c100 == CENT_LAST) begin
            step.next.c100 = 7'd0;
            step.next.c400 = cur.c400 + 2'd1;
          end else begin
            step.next.c100 = cur.c100 + 7'd1;
          end
        end
      end else begin
        step.next.month = cur.month + 4'd1;
      end
    end else begin
      step.next.day = cur.day + 5'd1;
    end
  end

endmodule

// ----- rtl/working_day_date_adder_core.sv -----
// Working-day date adder: top level with sequencer, registers and handshakes.
// Depends on wdda_pkg, wdda_div_unit, wdda_cal_step and assert_macros.svh.
//
// One transaction at a time: after acceptance the block finds the start weekday
// by repeated compare-and-subtract on one shared unit (400-, 100- and 4-year
// steps, a fix-up step, then mod-7 steps), then walks one calendar day per cycle
// until the working days are used up. The result is held in an output register;
// the next transaction may be accepted while it waits. A weekend mask with all
// seven days set counts every day as a working day. Walking past 31 Dec 9999
// stops there and raises year_overflow.
`include "assert_macros.svh"

module working_day_date_adder_core
  import wdda_pkg::*;
#(
  parameter int MAX_WORK_DAYS = 4095
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_weekend_mask,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [13:0] in_start_year,
  input  logic [3:0]  in_start_month,
  input  logic [4:0]  in_start_day,
  input  logic [11:0] in_work_days,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_end_year,
  output logic [3:0]  out_end_month,
  output logic [4:0]  out_end_day,
  output logic [2:0]  out_end_weekday,
  output logic        out_year_overflow
);

  localparam int LW = $clog2(MAX_WORK_DAYS + 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_Q400 = 7'b0000010,
    ST_Q100 = 7'b0000100,
    ST_Q4   = 7'b0001000,
    ST_FIX  = 7'b0010000,
    ST_MOD7 = 7'b0100000,
    ST_WALK = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  wdda_date_t        date_r, date_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [2:0]        acc_r, acc_nxt;
  logic [2:0]        wd_r, wd_nxt;
  logic [LW-1:0]     left_r, left_nxt;
  logic [6:0]        mask_r, mask_nxt;
  logic [6:0]        cfg_mask_r;
  logic              adj_r, adj_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [13:0]       out_year_r;
  logic [3:0]        out_month_r;
  logic [4:0]        out_day_r;
  logic [2:0]        out_wd_r;
  logic              out_ovf_r;
  logic              load_out;
  logic              load_ovf;

  logic [REM_W-1:0]  divisor;
  logic [REM_W-1:0]  diff;
  logic              ge;
  wdda_step_t        step;

  logic [13:0]       y_cl;
  logic [3:0]        m_cl;
  logic [31:0]       left_cl;
  logic [4:0]        d_fix;
  logic              can_out;

  wdda_div_unit u_div (
    .rem     (rem_r),
    .divisor (divisor),
    .diff    (diff),
    .ge      (ge)
  );

  wdda_cal_step u_step (
    .cur  (date_r),
    .step (step)
  );

  function automatic logic [2:0] add5_mod7(input logic [2:0] v);
    return (v >= 3'd2) ? v - 3'd2 : v + 3'd5;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign can_out   = !out_valid_r || out_ready;

  always_comb begin
    unique case (state_r)
      ST_Q400: divisor = DIV_400;
      ST_Q100: divisor = DIV_100;
      ST_Q4:   divisor = DIV_4;
      ST_MOD7: divisor = DIV_7;
      default: divisor = '0;
    endcase
  end

  always_comb begin
    y_cl = in_start_year;
    if (in_start_year < YEAR_MIN) y_cl = YEAR_MIN;
    if (in_start_year > YEAR_MAX) y_cl = YEAR_MAX;
    m_cl = in_start_month;
    if (in_start_month < 4'd1) m_cl = 4'd1;
    if (in_start_month > MONTH_DEC) m_cl = MONTH_DEC;
    left_cl = {20'd0, in_work_days};
    if (left_cl > 32'(MAX_WORK_DAYS)) left_cl = 32'(MAX_WORK_DAYS);
    d_fix = (date_r.day > step.mlen) ? step.mlen : date_r.day;
  end

  always_comb begin
    state_nxt = state_r;
    date_nxt  = date_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    wd_nxt    = wd_r;
    left_nxt  = left_r;
    mask_nxt  = mask_r;
    adj_nxt   = adj_r;
    load_out  = 1'b0;
    load_ovf  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          date_nxt.year  = y_cl;
          date_nxt.month = m_cl;
          date_nxt.day   = (in_start_day == 5'd0) ? 5'd1 : in_start_day;
          date_nxt.c100  = 7'd0;
          date_nxt.c400  = 2'd0;
          adj_nxt        = (m_cl <= MONTH_FEB);
          rem_nxt        = y_cl - {13'd0, (m_cl <= MONTH_FEB)};
          acc_nxt        = 3'd0;
          left_nxt       = LW'(left_cl);
          mask_nxt       = (cfg_mask_r == MASK_ALL) ? 7'd0 : cfg_mask_r;
          state_nxt      = ST_Q400;
        end
      end
      ST_Q400: begin
        if (ge) begin
          rem_nxt = diff;
        end else begin
          state_nxt = ST_Q100;
        end
      end
      ST_Q100: begin
        if (ge) begin
          rem_nxt       = diff;
          date_nxt.c400 = date_r.c400 + 2'd1;
          acc_nxt       = add5_mod7(acc_r);
        end else begin
          if (adj_r && (rem_r[6:0] == CENT_LAST)) begin
            date_nxt.c100 = 7'd0;
            date_nxt.c400 = date_r.c400 + 2'd1;
          end else begin
            date_nxt.c100 = rem_r[6:0] + {6'd0, adj_r};
          end
          state_nxt = ST_Q4;
        end
      end
      ST_Q4: begin
        if (ge) begin
          rem_nxt = diff;
          acc_nxt = add5_mod7(acc_r);
        end else begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        date_nxt.day = d_fix;
        rem_nxt = REM_W'(acc_r) + REM_W'(rem_r[1:0]) + REM_W'(d_fix) +
                  REM_W'(month_offset(date_r.month));
        state_nxt = ST_MOD7;
      end
      ST_MOD7: begin
        if (ge) begin
          rem_nxt = diff;
        end else begin
          wd_nxt    = rem_r[2:0];
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if ((left_r == '0) || step.overflow) begin
          if (can_out) begin
            load_out  = 1'b1;
            load_ovf  = (left_r != '0);
            state_nxt = ST_IDLE;
          end
        end else begin
          if (!mask_r[wd_r]) left_nxt = left_r - LW'(1);
          date_nxt = step.next;
          wd_nxt   = (wd_r == WD_SAT) ? 3'd0 : wd_r + 3'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cfg_mask_r  <= MASK_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) cfg_mask_r <= cfg_weekend_mask;
    end
  end

  always_ff @(posedge clk) begin
    date_r <= date_nxt;
    rem_r  <= rem_nxt;
    acc_r  <= acc_nxt;
    wd_r   <= wd_nxt;
    left_r <= left_nxt;
    mask_r <= mask_nxt;
    adj_r  <= adj_nxt;
    if (load_out) begin
      out_year_r  <= date_r.year;
      out_month_r <= date_r.month;
      out_day_r   <= date_r.day;
      out_wd_r    <= wd_r;
      out_ovf_r   <= load_ovf;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_end_year      = out_year_r;
  assign out_end_month     = out_month_r;
  assign out_end_day       = out_day_r;
  assign out_end_weekday   = out_wd_r;
  assign out_year_overflow = out_ovf_r;

  `WDDA_ASSERT_IMPL(a_ovf_date, out_valid_r && out_ovf_r, (out_year_r == YEAR_MAX) && (out_month_r == MONTH_DEC) && (out_day_r == 5'd31) && (out_wd_r == 3'd5), "overflow result is not Friday 31 Dec 9999")
  `WDDA_ASSERT_IMPL(a_walk_day, state_r == ST_WALK, (date_r.day >= 5'd1) && (date_r.day <= step.mlen) && (wd_r <= WD_SAT) && (date_r.c100 <= CENT_LAST), "walk date out of range")
  `WDDA_ASSERT(a_load_slot, load_out |-> (!out_valid_r || out_ready), "result loaded over an untaken result")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for working_day_date_adder_core: a queue-fed driver,
// a monitor and a calendar walk that predicts every end date for the mask in force.
// Depends on wdda_pkg and the core RTL.
`timescale 1ns / 100ps

module tb
  import wdda_pkg::*;
();

  localparam int unsigned MAX_DAYS = 4095;
  localparam logic [6:0] MASK_NONE = 7'h00;
  localparam logic [6:0] MASK_SAT_SUN = 7'h41;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 6000;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [11:0] work_days;
  } start_date_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic        overflow;
  } end_date_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_weekend_mask = MASK_RESET;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [13:0] in_start_year = '0;
  logic [3:0]  in_start_month = '0;
  logic [4:0]  in_start_day = '0;
  logic [11:0] in_work_days = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] out_end_year;
  logic [3:0]  out_end_month;
  logic [4:0]  out_end_day;
  logic [2:0]  out_end_weekday;
  logic        out_year_overflow;

  start_date_t start_dates[$];
  end_date_t   due_dates[$];
  logic [6:0]  weekend_now = MASK_RESET;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_cnt = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_overflow = 0;
  int          n_masks = 0;
  int          n_blocked = 0;
  int          n_fail = 0;

  working_day_date_adder_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_weekend_mask (cfg_weekend_mask),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_work_days     (in_work_days),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_end_year     (out_end_year),
    .out_end_month    (out_end_month),
    .out_end_day      (out_end_day),
    .out_end_weekday  (out_end_weekday),
    .out_year_overflow(out_year_overflow)
  );

  always #2 clk = ~clk;

  function automatic int unsigned days_of_month(int unsigned y, int unsigned m);
    bit leap;
    leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    case (m)
      32'(MONTH_FEB): return leap ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  // Sunday is 0.
  function automatic int unsigned weekday_num(int unsigned y, int unsigned m,
                                              int unsigned d);
    int unsigned shift;
    case (m)
      2, 6: shift = 3;
      3, 11: shift = 2;
      4, 7: shift = 5;
      8: shift = 1;
      9, 12: shift = 4;
      10: shift = 6;
      default: shift = 0;
    endcase
    if (m < 3) y = y - 1;
    return (y + y / 4 - y / 100 + y / 400 + shift + d) % 7;
  endfunction

  function automatic end_date_t walk_working_days(start_date_t s, logic [6:0] wmask);
    int unsigned y, m, d, left, wd;
    logic [6:0]  off_days;
    end_date_t   res;
    off_days = (wmask == MASK_ALL) ? MASK_NONE : wmask;
    y = 32'(s.year);
    m = 32'(s.month);
    d = 32'(s.day);
    left = 32'(s.work_days);
    if (y < 32'(YEAR_MIN)) y = 32'(YEAR_MIN);
    if (y > 32'(YEAR_MAX)) y = 32'(YEAR_MAX);
    if (m < 1) m = 1;
    if (m > 32'(MONTH_DEC)) m = 32'(MONTH_DEC);
    if (d < 1) d = 1;
    if (d > days_of_month(y, m)) d = days_of_month(y, m);
    if (left > MAX_DAYS) left = MAX_DAYS;
    wd = weekday_num(y, m, d);
    res.overflow = 1'b0;
    while (left > 0) begin
      if (!off_days[3'(wd)]) left--;
      if (d >= days_of_month(y, m)) begin
        if (m >= 32'(MONTH_DEC)) begin
          if (y >= 32'(YEAR_MAX)) begin
            res.overflow = 1'b1;
            break;
          end
          y++;
          m = 1;
        end else begin
          m++;
        end
        d = 1;
      end else begin
        d++;
      end
      wd = (wd + 1) % 7;
    end
    res.year = 14'(y);
    res.month = 4'(m);
    res.day = 5'(d);
    res.weekday = 3'(weekday_num(y, m, d));
    return res;
  endfunction

  task automatic flag_error(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("ERROR: %s", msg);
  endtask

  task automatic add_date(input int unsigned y, m, d, w);
    start_date_t s;
    s.year = 14'(y);
    s.month = 4'(m);
    s.day = 5'(d);
    s.work_days = 12'(w);
    start_dates.push_back(s);
  endtask

  task automatic queue_random(input int n, input int big_at);
    start_date_t s;
    int unsigned sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99, 0);
      if (sel < 12) begin
        s.year = 14'($urandom_range(16383, 0));
        s.month = 4'($urandom_range(15, 0));
        s.day = 5'($urandom_range(31, 0));
      end else begin
        if (sel < 22) begin
          s.year = 14'($urandom_range(32'(YEAR_MAX), 32'(YEAR_MAX) - 9));
          s.month = 4'($urandom_range(32'(MONTH_DEC), 10));
        end else begin
          s.year = 14'($urandom_range(32'(YEAR_MAX), 32'(YEAR_MIN)));
          s.month = 4'($urandom_range(32'(MONTH_DEC), 1));
        end
        s.day = 5'($urandom_range(days_of_month(32'(s.year), 32'(s.month)), 1));
      end
      if (i == big_at) s.work_days = 12'($urandom_range(MAX_DAYS, 2000));
      else if (sel >= 12 && sel < 22) s.work_days = 12'($urandom_range(150, 0));
      else s.work_days = 12'($urandom_range(63, 0));
      start_dates.push_back(s);
    end
  endtask

  task automatic settle();
    while (start_dates.size() != 0 || in_valid || due_dates.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_mask(input logic [6:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_weekend_mask <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(negedge clk);
    weekend_now = v;
    n_masks++;
  endtask

  // Driver: advance to the next pending start date once the current one is taken.
  always @(posedge clk) begin : drive_p
    start_date_t s;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        s.year = in_start_year;
        s.month = in_start_month;
        s.day = in_start_day;
        s.work_days = in_work_days;
        due_dates.push_back(walk_working_days(s, weekend_now));
        n_sent++;
      end
      if (start_dates.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        s = start_dates.pop_front();
        in_valid <= 1'b1;
        in_start_year <= s.year;
        in_start_month <= s.month;
        in_start_day <= s.day;
        in_work_days <= s.work_days;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Hold off the result channel once so the core backs up into its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      if (in_valid && !in_ready) n_blocked <= n_blocked + 1;
    end else if (hold_armed && !hold_done) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor_p
    end_date_t want, got;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.year = out_end_year;
        got.month = out_end_month;
        got.day = out_end_day;
        got.weekday = out_end_weekday;
        got.overflow = out_year_overflow;
        n_checked++;
        if (got.overflow === 1'b1) n_overflow++;
        if (due_dates.size() == 0) begin
          flag_error($sformatf("unexpected result %0d-%0d-%0d", got.year, got.month,
                               got.day));
        end else begin
          want = due_dates.pop_front();
          if (got.year !== want.year || got.month !== want.month ||
              got.day !== want.day || got.weekday !== want.weekday ||
              got.overflow !== want.overflow)
            flag_error($sformatf(
              "got %0d-%0d-%0d wd %0d ovf %0d, expected %0d-%0d-%0d wd %0d ovf %0d",
              got.year, got.month, got.day, got.weekday, got.overflow,
              want.year, want.month, want.day, want.weekday, want.overflow));
        end
      end
      out_ready <= (hold_cnt == 0) && ($urandom_range(99, 0) >= stall_pct);
    end
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_date(2024, 2, 29, 0);
    add_date(1, 1, 1, 0);
    add_date(0, 0, 0, 5);
    add_date(16383, 15, 31, 0);
    add_date(9999, 12, 31, 1);
    add_date(9999, 12, 25, 4095);
    add_date(2023, 2, 31, 1);
    add_date(2024, 2, 30, 3);
    add_date(2000, 2, 29, 10);
    add_date(1900, 2, 28, 2);
    add_date(2023, 4, 31, 1);
    add_date(2023, 12, 30, 5);
    add_date(1, 1, 1, 4095);
    add_date(5000, 7, 7, 4095);
    add_date(2023, 1, 31, 1);
    add_date(9998, 12, 31, 300);
    add_date(9999, 1, 1, 4095);
    add_date(1999, 12, 31, 2000);
    settle();

    write_mask(MASK_ALL);
    add_date(2024, 3, 1, 1);
    add_date(2023, 12, 29, 7);
    add_date(9999, 12, 31, 0);
    add_date(1, 1, 1, 4095);
    settle();

    write_mask(MASK_NONE);
    hold_armed = 1'b1;
    queue_random(20, 17);
    settle();

    write_mask(MASK_SAT_SUN);
    idle_pct = 47;
    queue_random(20, 7);
    settle();

    write_mask(7'($urandom_range(127, 0)));
    idle_pct = 0;
    stall_pct = 47;
    queue_random(20, 13);
    settle();

    write_mask(7'($urandom_range(127, 0)));
    idle_pct = 18;
    stall_pct = 18;
    queue_random(20, 3);
    settle();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (due_dates.size() != 0)
      flag_error($sformatf("%0d end dates never arrived", due_dates.size()));

    $display("Checked %0d end dates from %0d start dates under %0d masks, %0d at year limit.",
             n_checked, n_sent, n_masks, n_overflow);
    $display("Input held back for %0d cycles while results were blocked.", n_blocked);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/wdda_pkg.sv
rtl/wdda_div_unit.sv
rtl/wdda_cal_step.sv
rtl/working_day_date_adder_core.sv
test/tb.sv
